@@ hw/rtl/x128p_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// x128p_pkg
// Shared types and constants for the xorshift128+ uniform generator.
// ----------------------------------------------------------------------------
package x128p_pkg;

   // generator parameters
   localparam int RANGE_BITS_DEF = 32;

   // request codes
   localparam logic [1:0] REQ_DRAW   = 2'd0;
   localparam logic [1:0] REQ_RESEED = 2'd1;
   localparam logic [1:0] REQ_RANGE  = 2'd2;

   // splitmix64 constants
   localparam logic [63:0] MIX_GOLDEN = 64'h9E3779B97F4A7C15;
   localparam logic [63:0] MIX_MUL_A  = 64'hBF58476D1CE4E5B9;
   localparam logic [63:0] MIX_MUL_B  = 64'h94D049BB133111EB;

   // fraction position inside the raw word
   localparam int FRAC_BITS  = 53;
   localparam int FRAC_SHIFT = 64 - FRAC_BITS;

   // csr map: 64-bit registers on an 8-byte stride
   localparam int         CSR_ADDR_W   = 4;
   localparam int         CSR_DATA_W   = 64;
   localparam logic [0:0] CSR_IDX_SEED = 1'b0;

   typedef struct packed {
      logic [1:0]         req_type;
      logic signed [31:0] range_min;
      logic signed [31:0] range_max;
   } x128p_req_type;

   typedef struct packed {
      logic [63:0]          raw_word;
      logic [FRAC_BITS-1:0] unit_fraction;
      logic signed [31:0]   range_value;
      logic                 range_error;
   } x128p_rsp_type;

   // multiplier handshake
   typedef struct packed {
      logic        start;
      logic [63:0] op_a;
      logic [63:0] op_b;
   } x128p_mul_req_type;

   typedef struct packed {
      logic         done;
      logic [127:0] product;
   } x128p_mul_rsp_type;

endpackage
`default_nettype wire

@@ hw/rtl/x128p_mul.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// x128p_mul
// Iterative 64x64 -> 128 multiplier, one 32x32 partial product per cycle.
// ----------------------------------------------------------------------------
module x128p_mul
   import x128p_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire x128p_mul_req_type mul_req,
   output x128p_mul_rsp_type      mul_rsp
);

   localparam logic [2:0] LAST_STEP = 3'd4;

   logic [63:0]  op_a_ff;
   logic [63:0]  op_b_ff;
   logic [2:0]   step_ff;
   logic         busy_ff;
   logic         pv_ff;
   logic         done_ff;
   logic [63:0]  prod_ff;
   logic [1:0]   wt_ff;
   logic [127:0] acc_ff;

   logic [31:0]  a_half;
   logic [31:0]  b_half;
   logic [127:0] prod_aligned;

   assign a_half = step_ff[0] ? op_a_ff[63:32] : op_a_ff[31:0];
   assign b_half = step_ff[1] ? op_b_ff[63:32] : op_b_ff[31:0];

   always_comb begin
      case (wt_ff)
         2'd0:    prod_aligned = {64'd0, prod_ff};
         2'd1:    prod_aligned = {32'd0, prod_ff, 32'd0};
         2'd2:    prod_aligned = {prod_ff, 64'd0};
         default: prod_aligned = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pv_ff   <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (mul_req.start) begin
            op_a_ff <= mul_req.op_a;
            op_b_ff <= mul_req.op_b;
            step_ff <= '0;
            busy_ff <= 1'b1;
            pv_ff   <= 1'b0;
            acc_ff  <= '0;
         end else if (busy_ff) begin
            if (pv_ff) begin
               acc_ff <= acc_ff + prod_aligned;
            end
            if (step_ff != LAST_STEP) begin
               prod_ff <= {32'd0, a_half} * {32'd0, b_half};
               wt_ff   <= {1'b0, step_ff[0]} + {1'b0, step_ff[1]};
               pv_ff   <= 1'b1;
               step_ff <= step_ff + 3'd1;
            end else begin
               pv_ff   <= 1'b0;
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign mul_rsp.done    = done_ff;
   assign mul_rsp.product = acc_ff;

endmodule
`default_nettype wire

@@ hw/rtl/x128p_csr.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// x128p_csr
// APB register file holding the 64-bit seed word.
// ----------------------------------------------------------------------------
module x128p_csr
   import x128p_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   output logic      [63:0]           seed_value
);

   logic [63:0] seed_ff;
   logic        sel_seed;

   // register index sits above the byte offset
   assign sel_seed = (paddr[CSR_ADDR_W-1:3] == CSR_IDX_SEED);
   assign pready   = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else if (psel && penable && pwrite && pready && sel_seed) begin
         seed_ff <= pwdata;
      end
   end

   assign prdata     = sel_seed ? seed_ff : '0;
   assign seed_value = seed_ff;

endmodule
`default_nettype wire

@@ hw/rtl/xorshift128plus_uniform_generator_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Draw, failed range draw and unused code: result registered, valid in the cycle after accept.
// Range draw: one pass of the 4-step 32x32 multiplier, then S_RANGE and S_DONE, which waits for a free result slot.
// Reseed: two SplitMix64 passes, each two products on the multiplier.
// Throughput: one draw every cycle while results drain; otherwise one transaction at a time.
// Reset: seed clears to 0 and the block runs a seeding pass (req_ready low)
// that leaves the state a reseed with seed 0 would give.
// ----------------------------------------------------------------------------
// xorshift128plus_uniform_generator_top
// Seedable xorshift128+ generator with SplitMix64 seeding and range scaling.
// ----------------------------------------------------------------------------
module xorshift128plus_uniform_generator_top
   import x128p_pkg::*;
#(
   parameter int RANGE_BITS = RANGE_BITS_DEF
)(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire x128p_req_type         req_data,
   // result channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output x128p_rsp_type              rsp_data,
   // configuration port
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   // low RANGE_BITS of a 64-bit word survive the final mask
   localparam logic [63:0] BOUND_MASK = (64'd1 << RANGE_BITS) - 64'd1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEED,
      S_MIX_A,
      S_MIX_B,
      S_RANGE,
      S_DONE
   } state_type;

   // ------------------------------------------------------------------------
   // helpers
   // ------------------------------------------------------------------------
   function automatic logic [63:0] mix_pre(input logic [63:0] x);
      logic [63:0] y;
      y = x + MIX_GOLDEN;
      return y ^ (y >> 30);
   endfunction

   // sign-extend bit RANGE_BITS-1 of the sign-extended bound
   function automatic logic [63:0] widen(input logic signed [31:0] f);
      logic [63:0] v;
      v = {{32{f[31]}}, f};
      return {{(64 - RANGE_BITS){v[RANGE_BITS-1]}}, v[RANGE_BITS-1:0]};
   endfunction

   // ------------------------------------------------------------------------
   // csr and shared multiplier
   // ------------------------------------------------------------------------
   logic [63:0]       seed_value;
   x128p_mul_req_type mul_req;
   x128p_mul_rsp_type mul_rsp;

   x128p_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .seed_value (seed_value)
   );

   x128p_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   // ------------------------------------------------------------------------
   // state
   // ------------------------------------------------------------------------
   state_type     state_ff,      state_in;
   logic [63:0]   word_first_ff, word_first_in;
   logic [63:0]   word_second_ff, word_second_in;
   logic [63:0]   mix_src_ff,    mix_src_in;    // seed for the coming pass
   logic [63:0]   first_tmp_ff,  first_tmp_in;  // first mix pass result
   logic          pass_ff,       pass_in;       // 0 first word, 1 second word
   logic          report_ff,     report_in;     // reseed owes a transaction
   logic [63:0]   lo_ff,         lo_in;         // widened range minimum
   x128p_rsp_type pend_ff,       pend_in;
   x128p_rsp_type rsp_ff,        rsp_in;
   logic          rsp_valid_ff,  rsp_valid_in;

   logic          slot_free;
   logic          accept;
   logic [63:0]   sum;
   logic [63:0]   xs_t;
   logic [63:0]   xs_second;
   logic [63:0]   bnd_lo;
   logic [63:0]   bnd_hi;
   logic [63:0]   bnd_size;
   logic          bnd_err;
   logic [63:0]   prod_lo;
   logic [63:0]   mix_mid;
   logic [63:0]   mix_out;
   logic [63:0]   scaled;
   logic [63:0]   range_full;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;

   // xorshift128+ step
   assign sum       = word_first_ff + word_second_ff;
   assign xs_t      = word_first_ff ^ (word_first_ff << 23);
   assign xs_second = xs_t ^ word_second_ff ^ (xs_t >> 17) ^ (word_second_ff >> 26);

   // range bounds
   assign bnd_lo   = widen(req_data.range_min);
   assign bnd_hi   = widen(req_data.range_max);
   assign bnd_err  = $signed(bnd_lo) > $signed(bnd_hi);
   assign bnd_size = bnd_hi - bnd_lo + 64'd1;

   // multiplier result taps
   assign prod_lo    = mul_rsp.product[63:0];
   assign mix_mid    = prod_lo ^ (prod_lo >> 27);
   assign mix_out    = prod_lo ^ (prod_lo >> 31);
   assign scaled     = mul_rsp.product[116:53];
   assign range_full = (lo_ff + scaled) & BOUND_MASK;

   always_comb begin
      state_in       = state_ff;
      word_first_in  = word_first_ff;
      word_second_in = word_second_ff;
      mix_src_in     = mix_src_ff;
      first_tmp_in   = first_tmp_ff;
      pass_in        = pass_ff;
      report_in      = report_ff;
      lo_in          = lo_ff;
      pend_in        = pend_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      mul_req        = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_in = '0;
               case (req_data.req_type)
                  REQ_DRAW: begin
                     rsp_in.raw_word      = sum;
                     rsp_in.unit_fraction = sum[63:FRAC_SHIFT];
                     word_first_in        = word_second_ff;
                     word_second_in       = xs_second;
                     rsp_valid_in         = 1'b1;
                  end
                  REQ_RESEED: begin
                     mix_src_in = seed_value;
                     pass_in    = 1'b0;
                     report_in  = 1'b1;
                     state_in   = S_SEED;
                  end
                  REQ_RANGE: begin
                     if (bnd_err) begin
                        rsp_in.range_error = 1'b1;
                        rsp_valid_in       = 1'b1;
                     end else begin
                        pend_in               = '0;
                        pend_in.raw_word      = sum;
                        pend_in.unit_fraction = sum[63:FRAC_SHIFT];
                        word_first_in         = word_second_ff;
                        word_second_in        = xs_second;
                        lo_in                 = bnd_lo;
                        mul_req.start         = 1'b1;
                        mul_req.op_a          = {{FRAC_SHIFT{1'b0}}, sum[63:FRAC_SHIFT]};
                        mul_req.op_b          = bnd_size;
                        state_in              = S_RANGE;
                     end
                  end
                  default: begin
                     // unused code: empty transaction, state kept
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_SEED: begin
            mul_req.start = 1'b1;
            mul_req.op_a  = mix_pre(mix_src_ff);
            mul_req.op_b  = MIX_MUL_A;
            state_in      = S_MIX_A;
         end
         S_MIX_A: begin
            if (mul_rsp.done) begin
               mul_req.start = 1'b1;
               mul_req.op_a  = mix_mid;
               mul_req.op_b  = MIX_MUL_B;
               state_in      = S_MIX_B;
            end
         end
         S_MIX_B: begin
            if (mul_rsp.done) begin
               if (!pass_ff) begin
                  first_tmp_in  = mix_out;
                  pass_in       = 1'b1;
                  mul_req.start = 1'b1;
                  mul_req.op_a  = mix_pre(mix_out);
                  mul_req.op_b  = MIX_MUL_A;
                  state_in      = S_MIX_A;
               end else begin
                  word_second_in = mix_out;
                  // all-zero state would lock up; force the first word to 1
                  word_first_in  = ((first_tmp_ff | mix_out) == 64'd0) ? 64'd1
                                                                       : first_tmp_ff;
                  pend_in        = '0;
                  state_in       = report_ff ? S_DONE : S_IDLE;
               end
            end
         end
         S_RANGE: begin
            if (mul_rsp.done) begin
               pend_in.range_value = range_full[31:0];
               state_in            = S_DONE;
            end
         end
         S_DONE: begin
            if (slot_free) begin
               rsp_in       = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         // power-up seeding pass with seed 0, no transaction owed
         state_ff     <= S_SEED;
         mix_src_ff   <= '0;
         pass_ff      <= 1'b0;
         report_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mix_src_ff   <= mix_src_in;
         pass_ff      <= pass_in;
         report_ff    <= report_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      word_first_ff  <= word_first_in;
      word_second_ff <= word_second_in;
      first_tmp_ff   <= first_tmp_in;
      lo_ff          <= lo_in;
      pend_ff        <= pend_in;
      rsp_ff         <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the xorshift128+ uniform generator.
// Drives draw, reseed, range-draw and unused request transactions through
// the valid/ready request channel, writes the seed over the APB-style port
// while the block is idle, and compares every result transaction, field by
// field, against an in-bench model of the generator state.
// ----------------------------------------------------------------------------
module tb;
   import x128p_pkg::*;

   // request code that the block has no operation for; it must answer with zeros
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   // only register: the 64-bit seed at index 0, 8-byte stride
   localparam logic [CSR_ADDR_W-1:0] SEED_CSR_ADDR = CSR_ADDR_W'(8 * CSR_IDX_SEED);

   localparam int RANDOM_PER_PHASE = 500;
   localparam int SETTLE_CYCLES    = 40;      // longer than a reseed pass
   localparam int CYCLE_LIMIT      = 500000;  // far above the slowest correct run

   // ------------------------------------------------------------------------
   // DUT connections; every input starts at a known value
   // ------------------------------------------------------------------------
   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   x128p_req_type         req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   x128p_rsp_type         rsp_data;
   logic                  psel      = 1'b0;
   logic                  penable   = 1'b0;
   logic                  pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr     = '0;
   logic [CSR_DATA_W-1:0] pwdata    = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   xorshift128plus_uniform_generator_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // 2 ns period
   initial begin
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Generator model: seed register plus the two xorshift128+ state words
   // ------------------------------------------------------------------------
   logic [63:0] seed_reg;
   logic [63:0] gen_a;
   logic [63:0] gen_b;

   // results still owed by the block, oldest first
   x128p_rsp_type pending_rsp_q[$];
   x128p_rsp_type rsp_want;

   // idle percentages per channel, changed per phase
   int unsigned tx_idle_pct = 0;
   int unsigned rx_idle_pct = 0;

   int fail_count   = 0;
   int cycle_count  = 0;
   int n_checked    = 0;
   int n_draw       = 0;
   int n_range      = 0;
   int n_range_err  = 0;
   int n_reseed     = 0;
   int n_unused     = 0;
   int n_seed_write = 0;

   function automatic logic [63:0] splitmix64(input logic [63:0] x);
      logic [63:0] z;
      z = x + MIX_GOLDEN;
      z = (z ^ (z >> 30)) * MIX_MUL_A;
      z = (z ^ (z >> 27)) * MIX_MUL_B;
      return z ^ (z >> 31);
   endfunction

   // The all-zero fixup can never fire: SplitMix64 is a bijection and maps
   // zero to a nonzero word, so both words cannot be zero together. Kept for
   // fidelity only.
   function automatic void load_state(input logic [63:0] seed);
      gen_a = splitmix64(seed);
      gen_b = splitmix64(gen_a);
      if (gen_a == 64'd0 && gen_b == 64'd0)
         gen_a = 64'd1;
   endfunction

   // returns the pre-update sum and advances xorshift128+
   function automatic logic [63:0] step_state();
      logic [63:0] s;
      logic [63:0] t;
      s     = gen_a + gen_b;
      t     = gen_a ^ (gen_a << 23);
      gen_a = gen_b;
      gen_b = t ^ gen_b ^ (t >> 17) ^ (gen_b >> 26);
      return s;
   endfunction

   // expected result of one accepted request; updates the model state
   function automatic x128p_rsp_type compute_generator_rsp(input x128p_req_type item);
      x128p_rsp_type rsp;
      logic [63:0]   lo_w;
      logic [63:0]   hi_w;
      logic [63:0]   span_w;
      logic [63:0]   sum_w;
      logic [127:0]  product;
      rsp = '0;
      case (item.req_type)
         REQ_DRAW: begin
            sum_w             = step_state();
            rsp.raw_word      = sum_w;
            rsp.unit_fraction = sum_w[63:FRAC_SHIFT];
            n_draw++;
         end
         REQ_RESEED: begin
            load_state(seed_reg);
            n_reseed++;
         end
         REQ_RANGE: begin
            lo_w = {{32{item.range_min[31]}}, item.range_min};
            hi_w = {{32{item.range_max[31]}}, item.range_max};
            n_range++;
            if ($signed(lo_w) > $signed(hi_w)) begin
               // rejected: flag only, state holds
               rsp.range_error = 1'b1;
               n_range_err++;
            end else begin
               span_w            = hi_w - lo_w + 64'd1;
               sum_w             = step_state();
               rsp.raw_word      = sum_w;
               rsp.unit_fraction = sum_w[63:FRAC_SHIFT];
               // exact floor(fraction * span / 2^53)
               product           = {75'd0, rsp.unit_fraction} * {64'd0, span_w};
               rsp.range_value   = lo_w[31:0] + product[FRAC_BITS +: 32];
            end
         end
         default: begin
            n_unused++;
         end
      endcase
      return rsp;
   endfunction

   // ------------------------------------------------------------------------
   // Receiver: random stall on rsp_ready, and the result checker
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp_q.size() == 0) begin
            $error("result transaction with nothing expected: raw_word %h",
                   rsp_data.raw_word);
            fail_count++;
         end else begin
            rsp_want = pending_rsp_q.pop_front();
            n_checked++;
            if (rsp_data.raw_word !== rsp_want.raw_word) begin
               $error("raw_word mismatch: expected %h, got %h",
                      rsp_want.raw_word, rsp_data.raw_word);
               fail_count++;
            end
            if (rsp_data.unit_fraction !== rsp_want.unit_fraction) begin
               $error("unit_fraction mismatch: expected %h, got %h",
                      rsp_want.unit_fraction, rsp_data.unit_fraction);
               fail_count++;
            end
            if (rsp_data.range_value !== rsp_want.range_value) begin
               $error("range_value mismatch: expected %0d, got %0d",
                      rsp_want.range_value, rsp_data.range_value);
               fail_count++;
            end
            if (rsp_data.range_error !== rsp_want.range_error) begin
               $error("range_error mismatch: expected %b, got %b",
                      rsp_want.range_error, rsp_data.range_error);
               fail_count++;
            end
         end
      end
   end

   // watchdog: a hung handshake or a missing result ends the run here
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_rsp_q.size());
         $display("xorshift128plus_uniform_generator_top verification failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Sender helpers
   // ------------------------------------------------------------------------

   // One request transaction. Valid is left high after acceptance so that
   // back-to-back transactions never lower and raise it in the same step;
   // callers that stop sending go through wait_drained.
   task automatic send_request(input logic [1:0] kind, input logic [31:0] lo,
                               input logic [31:0] hi);
      x128p_req_type item;
      item.req_type  = kind;
      item.range_min = lo;
      item.range_max = hi;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      pending_rsp_q.push_back(compute_generator_rsp(item));
   endtask

   // stop sending and hold off until every owed result is back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp_q.size() != 0)
         @(posedge clock);
   endtask

   // APB write: setup, access, register loads on the access edge
   task automatic write_seed(input logic [63:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= SEED_CSR_ADDR;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      seed_reg = value;
      n_seed_write++;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Random request mix: mostly draws and well-formed range draws with
   // spans from tiny to full width, some reseeds, rejected ranges and noise.
   task automatic send_random_request();
      int unsigned pick;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] tmp;
      longint      top;
      pick = $urandom_range(99);
      a    = $urandom;
      b    = $urandom;
      if (pick < 40) begin
         send_request(REQ_DRAW, a, b);
      end else if (pick < 75) begin
         case ($urandom_range(3))
            0:       top = longint'($signed(a)) + $urandom_range(15);
            1:       top = longint'($signed(a)) + $urandom_range(100000);
            2:       top = longint'($signed(a)) + longint'($urandom >> $urandom_range(31));
            default: begin
               if ($signed(a) > $signed(b)) begin
                  tmp = a;
                  a   = b;
                  b   = tmp;
               end
               top = longint'($signed(b));
            end
         endcase
         if (top > 64'sd2147483647)
            top = 64'sd2147483647;
         send_request(REQ_RANGE, a, top[31:0]);
      end else if (pick < 85) begin
         // unordered bounds: roughly half get rejected
         send_request(REQ_RANGE, a, b);
      end else if (pick < 92) begin
         send_request(REQ_RESEED, a, b);
      end else if (pick < 96) begin
         if (a == b) begin
            a = 32'h7FFF_FFFF;
            b = 32'h8000_0000;
         end else if ($signed(a) < $signed(b)) begin
            tmp = a;
            a   = b;
            b   = tmp;
         end
         send_request(REQ_RANGE, a, b);
      end else begin
         send_request(REQ_UNUSED, a, b);
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // State after reset must match a seed-0 load; a reseed with the reset
   // seed value must return to the same sequence.
   task automatic test_reset_state();
      tx_idle_pct = 10;
      rx_idle_pct = 30;
      send_request(REQ_DRAW, 32'h0, 32'h0);
      send_request(REQ_DRAW, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(REQ_DRAW, 32'h0, 32'h0);
      send_request(REQ_RESEED, 32'h0, 32'h0);
      send_request(REQ_DRAW, 32'h0, 32'h0);
      send_request(REQ_DRAW, 32'h0, 32'h0);
      wait_drained();
   endtask

   // Bound extremes, single-value ranges, min > max rejection and the
   // unused request code, under an all-ones seed and back to zero.
   task automatic test_directed_cases();
      write_seed(64'hFFFF_FFFF_FFFF_FFFF);
      send_request(REQ_RESEED, 32'h0, 32'h0);
      send_request(REQ_RANGE, 32'h8000_0000, 32'h7FFF_FFFF);  // full 2^32 span
      send_request(REQ_RANGE, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_request(REQ_RANGE, 32'h8000_0000, 32'h8000_0000);
      send_request(REQ_RANGE, 32'h0, 32'h0);
      send_request(REQ_RANGE, 32'hFFFF_FFFF, 32'h0);
      send_request(REQ_RANGE, 32'h0, 32'hFFFF_FFFF);          // min > max by one
      send_request(REQ_RANGE, 32'h7FFF_FFFF, 32'h8000_0000);  // widest rejection
      send_request(REQ_RANGE, 32'hFFFF_FF9C, 32'hFFFF_FFFF);  // -100 .. -1
      send_request(REQ_RANGE, 32'h0, 32'h1);
      send_request(REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(REQ_UNUSED, 32'h0, 32'h0);
      send_request(REQ_DRAW, 32'h0, 32'h0);
      wait_drained();
      write_seed(64'h0);
      send_request(REQ_RESEED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(REQ_DRAW, 32'h0, 32'h0);
      wait_drained();
   endtask

   // One random phase under a given idle profile and seed; halfway through
   // the sender holds until every result has returned.
   task automatic test_random_phase(input int unsigned tx_pct, input int unsigned rx_pct,
                                    input logic [63:0] seed);
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      write_seed(seed);
      send_request(REQ_RESEED, $urandom, $urandom);
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
         if (i == RANDOM_PER_PHASE / 2)
            wait_drained();
         send_random_request();
      end
      wait_drained();
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      seed_reg = 64'd0;
      load_state(64'd0);
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_directed_cases();
      test_random_phase(27, 86, {$urandom, $urandom});
      test_random_phase(86, 27, 64'h8000_0000_0000_0001);
      test_random_phase(0, 0, {$urandom, $urandom});

      // let any stray result show up before judging
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Checked %0d results: %0d draws, %0d range draws (%0d rejected), %0d reseeds,",
               n_checked, n_draw, n_range, n_range_err, n_reseed);
      $display("%0d unused-code requests, %0d seed writes, three idle profiles, %0d cycles.",
               n_unused, n_seed_write, cycle_count);
      if (fail_count == 0 && pending_rsp_q.size() == 0) begin
         $display("xorshift128plus_uniform_generator_top verification clean");
      end else begin
         $display("xorshift128plus_uniform_generator_top verification failed");
      end
      $finish;
   end

endmodule
